// ===== rtl/stack_machine_execute_defines.svh =====
// ----------------------------------------------------------------------------
// Stack machine execute assertion macros
// Concurrent check wrappers, empty in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef STACK_MACHINE_EXECUTE_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_DEFINES_SVH

`ifndef SYNTHESIS
`define SMX_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SMX_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SMX_ASSERT(name, prop, msg)
`define SMX_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== rtl/smx_pkg.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute package
// Opcodes, stop codes and the result beat layout.
// ----------------------------------------------------------------------------
package smx_pkg;

  typedef enum logic [7:0] {
    OP_PUSH  = 8'd1,
    OP_ADD   = 8'd2,
    OP_MUL   = 8'd3,
    OP_PRINT = 8'd4,
    OP_CALL  = 8'd5,
    OP_RET   = 8'd6,
    OP_HALT  = 8'd7
  } opcode_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_HALT    = 3'd1,
    ST_OVER    = 3'd2,
    ST_UNDER   = 3'd3,
    ST_UNKNOWN = 3'd4
  } status_t;

  typedef struct packed {
    logic [15:0] next_pc;
    logic        print_valid;
    logic [31:0] print_value;
    logic        stopped;
    status_t     status;
  } out_beat_t;

endpackage

// ===== rtl/smx_stack_ram.sv =====
// ----------------------------------------------------------------------------
// Stack machine operand RAM
// Single-port synchronous RAM, registered read data held until next read.
// ----------------------------------------------------------------------------
module smx_stack_ram #(
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [31:0]              wdata,
  output logic [31:0]              rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[addr] <= wdata;
    end
    if (rd_en) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== rtl/stack_machine_execute.sv =====
// ----------------------------------------------------------------------------
// Stack machine execute
// One instruction per input beat on a 32-bit operand stack.
// ----------------------------------------------------------------------------
// Input channel s_*: s_tuser is the opcode, s_tdata the following code word
// (PUSH value or CALL target). Output channel m_*: one result beat per
// instruction with the next fetch pc, the printed value and the run status.
// The top of stack lives in a register; the rest of the stack is in a
// single-port RAM. An instruction touches the RAM at most once, in its accept
// cycle (push of the old top, or read of the entry below the top), and
// completes when the registered read data has returned and the output
// register is free. A new instruction is not taken while one is in flight.
// The result sits in an output register, so the next instruction is taken
// while a result waits. If the receiver stalls and the output register is
// still full, the instruction in flight holds and s_tready stays low.
// Reset clears pc, stack count and status and leaves the machine running;
// no RAM clearing is needed. After a halt or error every later instruction
// returns the held pc and stop status and changes nothing.
// ----------------------------------------------------------------------------
`include "stack_machine_execute_defines.svh"

module stack_machine_execute #(
  parameter int STACK_DEPTH = 1024,
  parameter int PC_WIDTH    = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] operand_word
  input  logic [7:0]  s_tuser,   // [7:0] cmd
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [15:0] next_pc, [47:16] print_value,
                                 // [48] stopped, [51:49] status, rest zero
  output logic        m_tuser    // [0] print_valid
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

  logic [PC_WIDTH-1:0] pc, pc_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic                running, running_next;
  smx_pkg::status_t    stop_status, stop_status_next;
  logic [31:0]         tos, tos_next;

  logic                ex_valid;
  logic [7:0]          ex_cmd;
  logic [31:0]         ex_word;

  smx_pkg::out_beat_t  out, out_next;

  logic                accept, commit;
  logic                ram_wr, ram_rd;
  logic [CW-1:0]       cnt_m1, cnt_m2;
  logic [AW-1:0]       ram_addr;
  logic [31:0]         ram_rdata;
  logic [31:0]         pc_ext;
  logic [PC_WIDTH-1:0] pc_inc1, pc_inc2;
  logic                print_valid;
  logic [31:0]         print_value;

  assign s_tready = !ex_valid;
  assign accept   = s_tvalid && s_tready;
  assign commit   = ex_valid && (!m_tvalid || m_tready);

  assign cnt_m1 = cnt - CW'(1);
  assign cnt_m2 = cnt - CW'(2);

  // RAM access in the accept cycle
  always_comb begin
    ram_wr   = 1'b0;
    ram_rd   = 1'b0;
    ram_addr = cnt_m1[AW-1:0];
    if (accept && running) begin
      case (s_tuser)
        smx_pkg::OP_PUSH, smx_pkg::OP_CALL: begin
          ram_wr = (cnt < CNT_FULL) && (cnt != '0);
        end
        smx_pkg::OP_ADD, smx_pkg::OP_MUL, smx_pkg::OP_PRINT, smx_pkg::OP_RET: begin
          ram_rd   = cnt >= CW'(2);
          ram_addr = cnt_m2[AW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  smx_stack_ram #(
    .DEPTH(STACK_DEPTH)
  ) u_stack_ram (
    .clk  (clk),
    .wr_en(ram_wr),
    .rd_en(ram_rd),
    .addr (ram_addr),
    .wdata(tos),
    .rdata(ram_rdata)
  );

  assign pc_inc1 = pc + PC_WIDTH'(1);
  assign pc_inc2 = pc + PC_WIDTH'(2);

  // Complete the instruction in flight
  always_comb begin
    pc_next          = pc;
    cnt_next         = cnt;
    running_next     = running;
    stop_status_next = stop_status;
    tos_next         = tos;
    print_valid      = 1'b0;
    print_value      = '0;
    if (running) begin
      case (ex_cmd)
        smx_pkg::OP_PUSH: begin
          pc_next = pc_inc2;
          if (cnt >= CNT_FULL) begin
            stop_status_next = smx_pkg::ST_OVER;
          end else begin
            tos_next = ex_word;
            cnt_next = cnt + CW'(1);
          end
        end
        smx_pkg::OP_ADD, smx_pkg::OP_MUL: begin
          pc_next = pc_inc1;
          if (cnt < CW'(2)) begin
            stop_status_next = smx_pkg::ST_UNDER;
          end else begin
            tos_next = (ex_cmd == smx_pkg::OP_ADD) ? ram_rdata + tos : ram_rdata * tos;
            cnt_next = cnt_m1;
          end
        end
        smx_pkg::OP_PRINT: begin
          pc_next = pc_inc1;
          if (cnt == '0) begin
            stop_status_next = smx_pkg::ST_UNDER;
          end else begin
            print_valid = 1'b1;
            print_value = tos;
            tos_next    = ram_rdata;
            cnt_next    = cnt_m1;
          end
        end
        smx_pkg::OP_CALL: begin
          pc_next = pc_inc2;
          if (cnt >= CNT_FULL) begin
            stop_status_next = smx_pkg::ST_OVER;
          end else begin
            tos_next = 32'(pc_inc2);
            cnt_next = cnt + CW'(1);
            pc_next  = ex_word[PC_WIDTH-1:0];
          end
        end
        smx_pkg::OP_RET: begin
          pc_next = pc_inc1;
          if (cnt == '0) begin
            stop_status_next = smx_pkg::ST_UNDER;
          end else begin
            pc_next  = tos[PC_WIDTH-1:0];
            tos_next = ram_rdata;
            cnt_next = cnt_m1;
          end
        end
        smx_pkg::OP_HALT: begin
          pc_next          = pc_inc1;
          stop_status_next = smx_pkg::ST_HALT;
        end
        default: begin
          pc_next          = pc_inc1;
          stop_status_next = smx_pkg::ST_UNKNOWN;
        end
      endcase
      running_next = stop_status_next == smx_pkg::ST_OK;
    end
  end

  assign pc_ext = 32'(pc_next);

  always_comb begin
    out_next.next_pc     = pc_ext[15:0];
    out_next.print_valid = print_valid;
    out_next.print_value = print_value;
    out_next.stopped     = !running_next;
    out_next.status      = stop_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ex_valid    <= 1'b0;
      m_tvalid    <= 1'b0;
      pc          <= '0;
      cnt         <= '0;
      running     <= 1'b1;
      stop_status <= smx_pkg::ST_OK;
    end else begin
      if (accept) begin
        ex_valid <= 1'b1;
      end else if (commit) begin
        ex_valid <= 1'b0;
      end
      if (commit) begin
        m_tvalid    <= 1'b1;
        pc          <= pc_next;
        cnt         <= cnt_next;
        running     <= running_next;
        stop_status <= stop_status_next;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ex_cmd  <= s_tuser;
      ex_word <= s_tdata;
    end
    if (commit) begin
      tos <= tos_next;
      out <= out_next;
    end
  end

  assign m_tdata = {4'b0000, out.status, out.stopped, out.print_value, out.next_pc};
  assign m_tuser = out.print_valid;

  `SMX_ASSERT(a_cnt_bound, cnt <= CNT_FULL, "stack count beyond depth")
  `SMX_ASSERT(a_stop_sticky, !running |=> !running, "machine restarted after stop")
  `SMX_ASSERT_ALWAYS(a_print_ok, m_tvalid && m_tuser |-> !out.stopped && out.status == smx_pkg::ST_OK, "print beat with stop status")

endmodule

// ===== verif/stack_machine_execute_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Stack machine execute testbench
// Sends instruction beats with random gaps and checks each result beat
// against a scoreboard that executes the same instructions on its own stack.
// Traffic is mostly legal programs with random operands. Unless the run is to
// end on underflow, a pass fills the stack to capacity and works around the
// full mark. The run ends with one stop condition, chosen at random, and then
// noise beats that the stopped machine must ignore.
// ----------------------------------------------------------------------------
module stack_machine_execute_tb;

  localparam int STACK_DEPTH  = 1024;
  localparam int RANDOM_ITEMS = 850;
  localparam int LONG_ITEMS   = 1850;
  localparam int SOFT_DEPTH   = 48;

  class smx_scoreboard;
    logic [15:0]         pc;
    logic [31:0]         stack_mem [STACK_DEPTH];
    int unsigned         depth;
    int unsigned         max_depth;
    bit                  running;
    smx_pkg::status_t    stop_code;
    smx_pkg::out_beat_t  expected_q[$];
    int unsigned         errors;
    int unsigned         checked;
    int unsigned         prints;

    function new();
      pc        = '0;
      depth     = 0;
      max_depth = 0;
      running   = 1'b1;
      stop_code = smx_pkg::ST_OK;
      errors    = 0;
      checked   = 0;
      prints    = 0;
    endfunction

    task report_mismatch(input string msg);
      if (errors < 50) $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Execute one accepted instruction and queue the result beat it implies.
    function void note_instr(input logic [7:0] cmd, input logic [31:0] word);
      smx_pkg::out_beat_t res;
      smx_pkg::status_t   st;
      logic [31:0]        a;
      logic [31:0]        b;
      res = '0;
      if (running) begin
        st = smx_pkg::ST_OK;
        case (cmd)
          smx_pkg::OP_PUSH: begin
            pc = pc + 16'd2;
            if (depth >= STACK_DEPTH) st = smx_pkg::ST_OVER;
            else begin
              stack_mem[depth] = word;
              depth++;
            end
          end
          smx_pkg::OP_ADD, smx_pkg::OP_MUL: begin
            pc = pc + 16'd1;
            if (depth < 2) st = smx_pkg::ST_UNDER;
            else begin
              b = stack_mem[depth-1];
              a = stack_mem[depth-2];
              stack_mem[depth-2] = (cmd == smx_pkg::OP_ADD) ? a + b : a * b;
              depth--;
            end
          end
          smx_pkg::OP_PRINT: begin
            pc = pc + 16'd1;
            if (depth < 1) st = smx_pkg::ST_UNDER;
            else begin
              depth--;
              res.print_valid = 1'b1;
              res.print_value = stack_mem[depth];
              prints++;
            end
          end
          smx_pkg::OP_CALL: begin
            pc = pc + 16'd2;
            if (depth >= STACK_DEPTH) st = smx_pkg::ST_OVER;
            else begin
              stack_mem[depth] = {16'b0, pc};
              depth++;
              pc = word[15:0];
            end
          end
          smx_pkg::OP_RET: begin
            pc = pc + 16'd1;
            if (depth < 1) st = smx_pkg::ST_UNDER;
            else begin
              depth--;
              pc = stack_mem[depth][15:0];
            end
          end
          smx_pkg::OP_HALT: begin
            pc = pc + 16'd1;
            st = smx_pkg::ST_HALT;
          end
          default: begin
            pc = pc + 16'd1;
            st = smx_pkg::ST_UNKNOWN;
          end
        endcase
        if (st != smx_pkg::ST_OK) begin
          running   = 1'b0;
          stop_code = st;
        end
        if (depth > max_depth) max_depth = depth;
      end
      res.next_pc = pc;
      res.stopped = !running;
      res.status  = stop_code;
      expected_q.push_back(res);
    endfunction

    task check_result(input logic [55:0] data, input logic user);
      smx_pkg::out_beat_t exp;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result beat %h with nothing expected", data));
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (data[15:0] !== exp.next_pc)
        report_mismatch($sformatf("next_pc %h, expected %h", data[15:0], exp.next_pc));
      if (user !== exp.print_valid)
        report_mismatch($sformatf("print_valid %b, expected %b", user, exp.print_valid));
      if (data[47:16] !== exp.print_value)
        report_mismatch($sformatf("print_value %h, expected %h", data[47:16],
                                  exp.print_value));
      if (data[48] !== exp.stopped)
        report_mismatch($sformatf("stopped %b, expected %b", data[48], exp.stopped));
      if (data[51:49] !== exp.status)
        report_mismatch($sformatf("status %0d, expected %0d", data[51:49], exp.status));
      if (data[55:52] !== 4'b0)
        report_mismatch($sformatf("pad bits %h not zero", data[55:52]));
    endtask
  endclass

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;
  logic [7:0]  s_tuser  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;
  logic        m_tuser;

  smx_scoreboard    sb = new();
  bit               no_idle = 1'b0;
  int unsigned      sent = 0;
  smx_pkg::status_t stop_kind;
  smx_pkg::status_t stop_menu [4] = '{smx_pkg::ST_HALT, smx_pkg::ST_OVER,
                                      smx_pkg::ST_UNDER, smx_pkg::ST_UNKNOWN};

  stack_machine_execute u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("stack_machine_execute verification failed");
    $finish;
  end

  task automatic send_instr(input logic [7:0] cmd, input logic [31:0] word);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= word;
    do @(posedge clk); while (!s_tready);
    sb.note_instr(cmd, word);
    sent++;
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (sb.expected_q.size() != 0);
  endtask

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      default: return $urandom();
    endcase
  endfunction

  // Legal opcode for the current depth; grow_pct biases toward push/call.
  function automatic logic [7:0] pick_op(input int unsigned depth,
                                         input int unsigned grow_pct);
    int r;
    if (depth == 0 || (depth < STACK_DEPTH && $urandom_range(1, 100) <= grow_pct))
      return ($urandom_range(0, 3) == 0) ? smx_pkg::OP_CALL : smx_pkg::OP_PUSH;
    r = $urandom_range(0, 3);
    if (depth == 1 && r < 2) r = 2 + $urandom_range(0, 1);
    case (r)
      0:       return smx_pkg::OP_ADD;
      1:       return smx_pkg::OP_MUL;
      2:       return smx_pkg::OP_PRINT;
      default: return smx_pkg::OP_RET;
    endcase
  endfunction

  initial begin : result_sink
    int stall;
    wait (!rst);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      sb.check_result(m_tdata, m_tuser);
    end
  end

  initial begin : stimulus
    int unsigned n;
    int unsigned grow;
    int unsigned n_rand;
    int unsigned target;
    logic [7:0]  cmd;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    stop_kind = stop_menu[$urandom_range(0, 3)];
    n_rand    = (stop_kind == smx_pkg::ST_UNDER) ? LONG_ITEMS : RANDOM_ITEMS;

    // directed: operand extremes, wrapping arithmetic, pc wrap, nested calls
    send_instr(smx_pkg::OP_PUSH,  32'h0000_0000);
    send_instr(smx_pkg::OP_PUSH,  32'h7FFF_FFFF);
    send_instr(smx_pkg::OP_PUSH,  32'h8000_0000);
    send_instr(smx_pkg::OP_PUSH,  32'hFFFF_FFFF);
    send_instr(smx_pkg::OP_ADD,   32'h0000_0000);
    send_instr(smx_pkg::OP_MUL,   32'hFFFF_FFFF);
    send_instr(smx_pkg::OP_PRINT, 32'h0000_0000);
    send_instr(smx_pkg::OP_PRINT, 32'hFFFF_FFFF);
    send_instr(smx_pkg::OP_PUSH,  32'h0000_0001);
    send_instr(smx_pkg::OP_PUSH,  32'hFFFF_FFFF);
    send_instr(smx_pkg::OP_ADD,   32'h5555_5555);
    send_instr(smx_pkg::OP_PRINT, 32'hAAAA_AAAA);
    send_instr(smx_pkg::OP_CALL,  32'hFFFF_FFFF);
    send_instr(smx_pkg::OP_PUSH,  32'h1234_5678);
    send_instr(smx_pkg::OP_PRINT, 32'h0000_0000);
    send_instr(smx_pkg::OP_RET,   32'h0000_0000);
    send_instr(smx_pkg::OP_CALL,  32'h8000_0000);
    send_instr(smx_pkg::OP_CALL,  32'h0000_7FFE);
    send_instr(smx_pkg::OP_RET,   32'hFFFF_FFFF);
    send_instr(smx_pkg::OP_RET,   32'h0000_0000);
    send_instr(smx_pkg::OP_PUSH,  $urandom());
    send_instr(smx_pkg::OP_PUSH,  $urandom());
    send_instr(smx_pkg::OP_MUL,   32'h0000_0000);
    send_instr(smx_pkg::OP_PRINT, 32'h0000_0000);

    grow = 50;
    for (n = 0; n < n_rand; n++) begin
      if (n % 150 == 0) begin
        grow    = $urandom_range(25, 75);
        no_idle = ($urandom_range(0, 3) == 0);
      end
      // hold off once until the block is empty
      if (n == n_rand / 2) wait_drained();
      send_instr(pick_op(sb.depth, (sb.depth > SOFT_DEPTH) ? 25 : grow), rand_word());
    end

    no_idle = 1'b0;
    if (stop_kind != smx_pkg::ST_UNDER) begin
      // fill the stack to the brim, then work around the full mark
      while (sb.depth < STACK_DEPTH)
        send_instr(($urandom_range(0, 7) == 0) ? smx_pkg::OP_CALL : smx_pkg::OP_PUSH,
                   rand_word());
      repeat (40) send_instr(pick_op(sb.depth, 50), rand_word());
    end

    case (stop_kind)
      smx_pkg::ST_HALT: send_instr(smx_pkg::OP_HALT, rand_word());
      smx_pkg::ST_OVER: begin
        while (sb.depth < STACK_DEPTH) send_instr(smx_pkg::OP_PUSH, rand_word());
        send_instr(($urandom_range(0, 1) == 0) ? smx_pkg::OP_CALL : smx_pkg::OP_PUSH,
                   rand_word());
      end
      smx_pkg::ST_UNDER: begin
        target = $urandom_range(0, 1);
        while (sb.depth > target) send_instr(pick_op(sb.depth, 0), rand_word());
        if (sb.depth == 1)
          send_instr(($urandom_range(0, 1) == 0) ? smx_pkg::OP_ADD : smx_pkg::OP_MUL,
                     rand_word());
        else
          send_instr(pick_op(2, 0), rand_word());
      end
      default: begin
        cmd = 8'($urandom_range(8, 255));
        if ($urandom_range(0, 7) == 0) cmd = 8'd0;
        send_instr(cmd, rand_word());
      end
    endcase

    // the stopped machine must hold its state whatever arrives
    repeat (40) send_instr(8'($urandom_range(0, 255)), $urandom());

    wait_drained();
    repeat (10) @(posedge clk);
    if (sb.expected_q.size() != 0)
      sb.report_mismatch($sformatf("%0d result beats never arrived", sb.expected_q.size()));

    $display("Ran %0d instructions, checked %0d result beats, %0d printed values.",
             sent, sb.checked, sb.prints);
    $display("Peak stack depth %0d; run ended on %s; %0d mismatches.",
             sb.max_depth, stop_kind.name(), sb.errors);
    if (sb.errors == 0) begin
      $display("stack_machine_execute verification clean");
    end else begin
      $display("stack_machine_execute verification failed");
    end
    $finish;
  end

endmodule
